// ===== rtl/adr_pkg.sv =====
// ----------------------------------------------------------------------------
// adr_pkg
// Shared types, constants and tables of the ADPCM nibble decoder / resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package adr_pkg;

	localparam int LevelW   = 15;
	localparam int IdxW     = 6;
	localparam int StepW    = 11;
	localparam int MagW     = 12;
	localparam int RateW    = 16;
	localparam int OutRateW = 14;
	localparam int PbRateW  = 13;
	localparam int CntW     = 3;
	localparam int QDepth   = 2;
	localparam int QPtrW    = $clog2(QDepth);

	localparam logic [IdxW-1:0]          StepTop = 6'd48;
	localparam logic [CntW-1:0]          MaxEmit = 3'd4;
	localparam logic signed [LevelW-1:0] LevelHi = 15'sh3FFF;
	localparam logic signed [LevelW-1:0] LevelLo = -15'sh4000;
	localparam logic signed [LevelW-1:0] LevelReset = -15'sd2;

	localparam logic [OutRateW-1:0] OutRateReset = 14'd8000;
	localparam logic [PbRateW-1:0]  PbRateReset  = 13'd5000;
	localparam logic signed [RateW-1:0] CounterReset = 16'sd4000;

	// register indexes of the write port
	localparam logic RegOutputRate   = 1'b0;
	localparam logic RegPlaybackRate = 1'b1;

	typedef struct packed {
		logic signed [LevelW-1:0] level;
		logic                     start;
	} entry_t;

	// floor(16 * 1.1^n), n = 0..48
	function automatic logic [StepW-1:0] step_value(input logic [IdxW-1:0] idx);
		logic [StepW-1:0] v;
		case (idx)
			6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;
			6'd3:  v = 11'd21;   6'd4:  v = 11'd23;   6'd5:  v = 11'd25;
			6'd6:  v = 11'd28;   6'd7:  v = 11'd31;   6'd8:  v = 11'd34;
			6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
			6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;
			6'd15: v = 11'd66;   6'd16: v = 11'd73;   6'd17: v = 11'd80;
			6'd18: v = 11'd88;   6'd19: v = 11'd97;   6'd20: v = 11'd107;
			6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
			6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;
			6'd27: v = 11'd209;  6'd28: v = 11'd230;  6'd29: v = 11'd253;
			6'd30: v = 11'd279;  6'd31: v = 11'd307;  6'd32: v = 11'd337;
			6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
			6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;
			6'd39: v = 11'd658;  6'd40: v = 11'd724;  6'd41: v = 11'd796;
			6'd42: v = 11'd876;  6'd43: v = 11'd963;  6'd44: v = 11'd1060;
			6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
			6'd48: v = 11'd1552;
			default: v = 11'd1552;
		endcase
		return v;
	endfunction

	function automatic logic signed [3:0] step_move(input logic [2:0] mag);
		logic signed [3:0] m;
		case (mag)
			3'd0: m = -4'sd1;
			3'd1: m = 4'sd1;
			3'd2: m = 4'sd1;
			3'd3: m = 4'sd2;
			3'd4: m = 4'sd2;
			3'd5: m = 4'sd3;
			3'd6: m = 4'sd5;
			3'd7: m = 4'sd7;
			default: m = 4'sd0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/adpcm_nibble_decoder_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder_resampler_unit
// 4-bit ADPCM decoder with output rate conversion by level repetition.
// ----------------------------------------------------------------------------
// The decoder takes one code per cycle into a two-entry queue, so input is
// accepted back to back until the queue fills. The repeat stage pops one
// code at a time from the queue and emits n output levels for it, where n
// (0 to 4) is set by the rate counter loop of that stage; it takes no new
// code until the last is done, and a stalled output holds it. Write the
// output rate and the playback rate only while the block is idle; the rate
// counter takes up the output rate when it reloads at a start request and
// when it adds the rate back at the end of each code.
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm_nibble_decoder_resampler_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic                                 wr_index,
	input  wire logic [adr_pkg::OutRateW-1:0]         wr_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [3:0]                           code,
	input  wire logic                                 start_req,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [adr_pkg::LevelW-1:0]         level,
	output logic                                      last
);

	logic [adr_pkg::OutRateW-1:0] output_rate_q;
	logic [adr_pkg::PbRateW-1:0]  pb_rate_q;

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	adr_pkg::entry_t push_entry;
	adr_pkg::entry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_rate_q <= adr_pkg::OutRateReset;
			pb_rate_q     <= adr_pkg::PbRateReset;
		end else if (wr_en) begin
			case (wr_index)
				adr_pkg::RegOutputRate:   output_rate_q <= wr_data;
				adr_pkg::RegPlaybackRate: pb_rate_q     <= wr_data[adr_pkg::PbRateW-1:0];
				default: ;
			endcase
		end
	end

	adr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code       (code),
		.start_req  (start_req),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	adr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	adr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.output_rate (output_rate_q),
		.pb_rate     (pb_rate_q),
		.q_empty     (q_empty),
		.pop_entry   (pop_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level       (level),
		.last        (last)
	);

endmodule

`default_nettype wire

// ===== rtl/adr_front.sv =====
// ----------------------------------------------------------------------------
// adr_front
// Accepts codes, decodes them into signal levels and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module adr_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [3:0]            code,
	input  wire logic                  start_req,
	input  wire logic                  q_full,
	output logic                       push,
	output adr_pkg::entry_t            push_entry
);

	logic signed [adr_pkg::LevelW-1:0] level_q;
	logic [adr_pkg::IdxW-1:0]          idx_q;
	logic [adr_pkg::IdxW-1:0]          idx_base;
	logic [adr_pkg::StepW-1:0]         step;
	logic [adr_pkg::MagW-1:0]          mag;
	logic signed [adr_pkg::LevelW:0]   sum;
	logic signed [adr_pkg::LevelW-1:0] level_next;
	logic signed [adr_pkg::IdxW+1:0]   idx_sum;
	logic [adr_pkg::IdxW-1:0]          idx_next;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// start restarts the step index before this code is decoded
	assign idx_base = start_req ? '0 : idx_q;
	assign step     = adr_pkg::step_value(idx_base);

	always_comb begin
		mag = adr_pkg::MagW'(step >> 3);
		if (code[2]) mag = mag + adr_pkg::MagW'(step);
		if (code[1]) mag = mag + adr_pkg::MagW'(step >> 1);
		if (code[0]) mag = mag + adr_pkg::MagW'(step >> 2);
	end

	always_comb begin
		if (code[3]) begin
			sum = {level_q[adr_pkg::LevelW-1], level_q} - $signed({4'b0, mag});
		end else begin
			sum = {level_q[adr_pkg::LevelW-1], level_q} + $signed({4'b0, mag});
		end
		if (sum > $signed({adr_pkg::LevelHi[adr_pkg::LevelW-1], adr_pkg::LevelHi})) begin
			level_next = adr_pkg::LevelHi;
		end else if (sum < $signed({adr_pkg::LevelLo[adr_pkg::LevelW-1],
				adr_pkg::LevelLo})) begin
			level_next = adr_pkg::LevelLo;
		end else begin
			level_next = sum[adr_pkg::LevelW-1:0];
		end
	end

	always_comb begin
		idx_sum = $signed({2'b0, idx_base}) + (adr_pkg::IdxW+2)'(adr_pkg::step_move(code[2:0]));
		if (idx_sum < 0) begin
			idx_next = '0;
		end else if (idx_sum > $signed({2'b0, adr_pkg::StepTop})) begin
			idx_next = adr_pkg::StepTop;
		end else begin
			idx_next = idx_sum[adr_pkg::IdxW-1:0];
		end
	end

	assign push_entry.level = level_next;
	assign push_entry.start = start_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= adr_pkg::LevelReset;
			idx_q   <= '0;
		end else if (push) begin
			level_q <= level_next;
			idx_q   <= idx_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adr_queue.sv =====
// ----------------------------------------------------------------------------
// adr_queue
// Short FIFO of decoded levels between the decoder and the repeat stage.
// ----------------------------------------------------------------------------
`default_nettype none

module adr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire adr_pkg::entry_t push_entry,
	input  wire logic            pop,
	output adr_pkg::entry_t      pop_entry,
	output logic                 full,
	output logic                 empty
);

	adr_pkg::entry_t              mem_q [adr_pkg::QDepth];
	logic [adr_pkg::QPtrW-1:0]    wr_ptr_q;
	logic [adr_pkg::QPtrW-1:0]    rd_ptr_q;
	logic [adr_pkg::QPtrW:0]      count_q;

	assign full      = count_q == (adr_pkg::QPtrW+1)'(adr_pkg::QDepth);
	assign empty     = count_q == '0;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adr_back.sv =====
// ----------------------------------------------------------------------------
// adr_back
// Rate counter: repeats each decoded level zero to four times into the
// output register and marks the final repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module adr_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [adr_pkg::OutRateW-1:0]  output_rate,
	input  wire logic [adr_pkg::PbRateW-1:0]   pb_rate,
	input  wire logic                          q_empty,
	input  wire adr_pkg::entry_t               pop_entry,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [adr_pkg::LevelW-1:0]  level,
	output logic                               last
);

	localparam logic StIdle = 1'b0;
	localparam logic StEmit = 1'b1;

	logic                               state_q;
	logic signed [adr_pkg::RateW-1:0]   rc_q;
	logic [adr_pkg::CntW-1:0]           cnt_q;
	logic signed [adr_pkg::LevelW-1:0]  cur_q;
	logic                               out_valid_q;
	logic signed [adr_pkg::LevelW-1:0]  level_q;
	logic                               last_q;

	logic                               slot_free;
	logic                               more;
	logic                               emit;
	logic signed [adr_pkg::RateW-1:0]   rc_sub;
	logic signed [adr_pkg::RateW:0]     rc_add;
	logic signed [adr_pkg::RateW-1:0]   rc_sat;

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign last      = last_q;

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == StIdle) && !q_empty;
	assign more      = (rc_q > 0) && (cnt_q != adr_pkg::MaxEmit);
	assign emit      = (state_q == StEmit) && more && slot_free;
	assign rc_sub    = rc_q - $signed({3'b0, pb_rate});
	assign rc_add    = {rc_q[adr_pkg::RateW-1], rc_q} + $signed({3'b0, output_rate});

	always_comb begin
		if (rc_add > 17'sd32767) begin
			rc_sat = 16'sh7FFF;
		end else if (rc_add < -17'sd32768) begin
			rc_sat = -16'sh8000;
		end else begin
			rc_sat = rc_add[adr_pkg::RateW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			rc_q        <= adr_pkg::CounterReset;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (!q_empty) begin
						if (pop_entry.start) begin
							rc_q <= adr_pkg::RateW'(output_rate >> 1);
						end
						cnt_q   <= '0;
						state_q <= StEmit;
					end
				end
				StEmit: begin
					if (more) begin
						// hold until the output register frees up
						if (slot_free) begin
							rc_q  <= rc_sub;
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						rc_q    <= rc_sat;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_entry.level;
		if (emit) begin
			level_q <= cur_q;
			last_q  <= (rc_sub <= 0) || (cnt_q == adr_pkg::MaxEmit - 1'b1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adr_checker.sv =====
// ----------------------------------------------------------------------------
// adr_checker
// Port-level checks of the decoder / resampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adr_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic signed [adr_pkg::LevelW-1:0] level,
	input  wire logic                          last
);

	// requests taken since the last marked one
	logic [1:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (out_valid && out_ready) begin
			run_q <= last ? 2'd0 : run_q + 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(last))
		else $error("output request changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output request during reset");

	a_fourth_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_q == 2'd3 |-> last)
		else $error("more than four repeats for one code");

	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$isunknown(in_ready))
		else $error("input ready unknown after a request");

endmodule

bind adpcm_nibble_decoder_resampler_unit adr_checker u_adr_checker (.*);

`default_nettype wire

// ===== bench/adpcm_level_checker.sv =====
// ----------------------------------------------------------------------------
// adpcm_level_checker
// Predicts and checks the decoded levels of the ADPCM decoder / resampler.
// ----------------------------------------------------------------------------
// Follows the register writes and every accepted code request, works out the
// levels that code must produce from a private copy of the decoder state, and
// compares them in order against the output channel. Errors and the number of
// levels still owed are handed to the bench top.
// ----------------------------------------------------------------------------
module adpcm_level_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic                              wr_index,
	input  logic [adr_pkg::OutRateW-1:0]      wr_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [3:0]                        code,
	input  logic                              start_req,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [adr_pkg::LevelW-1:0] level,
	input  logic                              last,
	output int                                fail_count,
	output int                                pending,
	output int                                levels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LevelMax   = 16383;
	localparam int LevelMin   = -16384;
	localparam int StepLast   = 48;
	localparam int MaxRepeat  = 4;
	localparam int CounterMax = 32767;
	localparam int CounterMin = -32768;

	// floor(16 * 1.1^n), index 0 leftmost
	localparam logic [0:48][10:0] StepTable = {
		11'd16,   11'd17,   11'd19,   11'd21,   11'd23,   11'd25,   11'd28,
		11'd31,   11'd34,   11'd37,   11'd41,   11'd45,   11'd50,   11'd55,
		11'd60,   11'd66,   11'd73,   11'd80,   11'd88,   11'd97,   11'd107,
		11'd118,  11'd130,  11'd143,  11'd157,  11'd173,  11'd190,  11'd209,
		11'd230,  11'd253,  11'd279,  11'd307,  11'd337,  11'd371,  11'd408,
		11'd449,  11'd494,  11'd544,  11'd598,  11'd658,  11'd724,  11'd796,
		11'd876,  11'd963,  11'd1060, 11'd1166, 11'd1282, 11'd1411, 11'd1552
	};

	// step index shift per magnitude
	localparam logic [0:7][3:0] IndexShift = {
		-4'sd1, 4'sd1, 4'sd1, 4'sd2, 4'sd2, 4'sd3, 4'sd5, 4'sd7
	};

	typedef struct packed {
		logic signed [adr_pkg::LevelW-1:0] level;
		logic                              last;
	} level_rec_t;

	level_rec_t expected_levels[$];

	int out_rate  = int'(adr_pkg::OutRateReset);
	int pb_rate   = int'(adr_pkg::PbRateReset);
	int sig_level = -2;
	int step_idx  = 0;
	int rate_cnt  = int'(adr_pkg::OutRateReset) / 2;
	int err_cnt   = 0;
	int n_checked = 0;

	task automatic decode_code(input logic [3:0] c, input logic st);
		level_rec_t rec;
		int stp;
		int mag;
		int n;
		if (st) begin
			step_idx = 0;
			rate_cnt = out_rate / 2;
		end
		stp = int'(StepTable[step_idx]);
		mag = stp / 8;
		if (c[2]) mag += stp;
		if (c[1]) mag += stp / 2;
		if (c[0]) mag += stp / 4;
		sig_level += c[3] ? -mag : mag;
		if (sig_level > LevelMax) sig_level = LevelMax;
		else if (sig_level < LevelMin) sig_level = LevelMin;

		step_idx += $signed(IndexShift[c[2:0]]);
		if (step_idx > StepLast) step_idx = StepLast;
		else if (step_idx < 0) step_idx = 0;

		// repeat the level while the counter is positive, capped
		n = 0;
		while (rate_cnt > 0 && n < MaxRepeat) begin
			rate_cnt -= pb_rate;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			rec.level = sig_level[adr_pkg::LevelW-1:0];
			rec.last = (k == n - 1);
			expected_levels.push_back(rec);
		end

		rate_cnt += out_rate;
		if (rate_cnt > CounterMax) rate_cnt = CounterMax;
		else if (rate_cnt < CounterMin) rate_cnt = CounterMin;
	endtask

	always @(posedge clk or negedge arst_n) begin
		level_rec_t want;
		if (!arst_n) begin
			out_rate = int'(adr_pkg::OutRateReset);
			pb_rate = int'(adr_pkg::PbRateReset);
			sig_level = -2;
			step_idx = 0;
			rate_cnt = out_rate / 2;
			expected_levels.delete();
		end else begin
			if (wr_en) begin
				if (wr_index == adr_pkg::RegOutputRate) out_rate = int'(wr_data);
				else pb_rate = int'(wr_data[adr_pkg::PbRateW-1:0]);
			end
			// push before popping so a same-edge pass-through still lines up
			if (in_valid && in_ready) decode_code(code, start_req);
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					$error("level: expected none, got %0d (last %0b)", level, last);
					err_cnt++;
				end else begin
					want = expected_levels.pop_front();
					if (level !== want.level) begin
						$error("level: expected %0d, got %0d", $signed(want.level), level);
						err_cnt++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						err_cnt++;
					end
					n_checked++;
				end
			end
		end
		fail_count <= err_cnt;
		pending <= expected_levels.size();
		levels_checked <= n_checked;
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the ADPCM nibble decoder / resampler.
// ----------------------------------------------------------------------------
// Sends a short directed set of codes at the reset rates, then random code
// streams under eight rate settings (extremes included) and four sender /
// receiver idling patterns. The checker beside the block predicts and
// compares every level; this module only drives stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit   = 400000;
	localparam int SettleCycles = 16;
	localparam int BlockItems   = 56;

	typedef enum int {RunAny, RunRise, RunFall, RunQuiet, RunNoise} run_kind_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              wr_en = 1'b0;
	logic                              wr_index = 1'b0;
	logic [adr_pkg::OutRateW-1:0]      wr_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [3:0]                        code = '0;
	logic                              start_req = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [adr_pkg::LevelW-1:0] level;
	logic                              last;

	int fail_count;
	int pending;
	int levels_checked;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int codes_sent = 0;
	int rate_settings = 0;
	int cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	adpcm_nibble_decoder_resampler_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code      (code),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.last      (last)
	);

	adpcm_level_checker level_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code           (code),
		.start_req      (start_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.level          (level),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.levels_checked (levels_checked)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_code(input logic [3:0] c, input logic st);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code <= c;
		start_req <= st;
		do @(posedge clk); while (!in_ready);
		codes_sent++;
	endtask

	// drop valid, wait for every owed level, then let a code with no output settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_rates(input logic [adr_pkg::OutRateW-1:0] out_r,
			input logic [adr_pkg::OutRateW-1:0] pb_r);
		wr_en <= 1'b1;
		wr_index <= adr_pkg::RegOutputRate;
		wr_data <= out_r;
		@(posedge clk);
		wr_index <= adr_pkg::RegPlaybackRate;
		wr_data <= pb_r;
		@(posedge clk);
		wr_en <= 1'b0;
		rate_settings++;
	endtask

	// runs of codes, most opened by a start request; the noise runs break that
	task automatic run_codes(input int n_items);
		run_kind_t kind;
		int run_len;
		int sent;
		logic [2:0] mag;
		logic sgn;
		logic st;
		sent = 0;
		while (sent < n_items) begin
			kind = run_kind_t'($urandom_range(RunNoise));
			run_len = $urandom_range(30, 6);
			for (int k = 0; k < run_len && sent < n_items; k++) begin
				mag = 3'($urandom_range(7));
				sgn = 1'($urandom_range(1));
				st = (k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(39) == 0);
				case (kind)
					RunRise: begin
						mag = 3'($urandom_range(7, 4));
						sgn = 1'b0;
					end
					RunFall: begin
						mag = 3'($urandom_range(7, 4));
						sgn = 1'b1;
					end
					RunQuiet: mag = 3'($urandom_range(1));
					RunNoise: st = 1'($urandom_range(1));
					default: ;
				endcase
				send_code({sgn, mag}, st);
				sent++;
			end
		end
	endtask

	initial begin
		int out_r;
		int pb_r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every code at the reset rates, then drive the step index to the top, rise, fall and restart
		send_code(4'd0, 1'b1);
		for (int c = 1; c < 16; c++) send_code(c[3:0], 1'b0);
		repeat (5) send_code(4'd7, 1'b0);
		repeat (3) send_code(4'd15, 1'b0);
		send_code(4'd8, 1'b1);

		for (int b = 0; b < 8; b++) begin
			drain();
			case (b)
				0: begin out_r = 8000; pb_r = 5000; end
				1: begin out_r = 16000; pb_r = 5000; end
				2: begin out_r = 4000; pb_r = 8000; end
				3: begin out_r = 16383; pb_r = 0; end
				4: begin out_r = 0; pb_r = 8191; end
				6: begin out_r = 14000; pb_r = 8192 + 6000; end
				default: begin
					out_r = $urandom_range(16000, 4000);
					pb_r = $urandom_range(8000, 5000) + 8192 * $urandom_range(1);
				end
			endcase
			set_rates(out_r[adr_pkg::OutRateW-1:0], pb_r[adr_pkg::OutRateW-1:0]);
			case (b % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 49; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 49; end
				default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
			endcase
			run_codes(BlockItems);
		end
		drain();

		$display("summary: %0d codes sent under %0d rate settings, %0d levels checked",
			codes_sent, rate_settings, levels_checked);
		$display("summary: idle patterns none, sender, receiver and both; %0d mismatches",
			fail_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== adpcm_nibble_decoder_resampler_unit.f =====
rtl/adr_pkg.sv
rtl/adr_front.sv
rtl/adr_queue.sv
rtl/adr_back.sv
rtl/adpcm_nibble_decoder_resampler_unit.sv
rtl/adr_checker.sv
bench/adpcm_level_checker.sv
bench/tb_top.sv
